// File: rtl/core/msns_pkg.sv
`timescale 1ns / 1ps
// Package for the multistage network switch setter: sizes, request,
// status and switch codes. No dependencies.
package msns_pkg;

  localparam int STAGES    = 8;
  localparam int STG_W     = $clog2(STAGES);
  localparam int HALF_W    = STAGES - 1;
  localparam int SW_AW     = STG_W + HALF_W;
  localparam int SW_DEPTH  = STAGES << HALF_W;
  localparam int BLK_DEPTH = 1 << STAGES;

  localparam int REQ_W    = 2;
  localparam int WIRE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int SWC_W    = 2;

  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ROUTE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TRACE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ROUTED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BLOCKED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISDIR    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DELIVERED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SKIPPED   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_UNSET     = 3'd6;
  localparam logic [STATUS_W-1:0] ST_WRONG     = 3'd7;

  localparam logic [SWC_W-1:0] SW_UNSET    = 2'd0;
  localparam logic [SWC_W-1:0] SW_STRAIGHT = 2'd1;
  localparam logic [SWC_W-1:0] SW_CROSS    = 2'd2;

endpackage

// File: rtl/core/msns_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests, results and configuration.
// Depends on msns_pkg.
interface msns_in_if import msns_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [WIRE_W-1:0]   src_wire;
  logic [WIRE_W-1:0]   dest_wire;
  modport source (output valid, req_type, src_wire, dest_wire, input ready);
  modport sink   (input valid, req_type, src_wire, dest_wire, output ready);
endinterface

interface msns_out_if import msns_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [WIRE_W-1:0]   reached_wire;
  modport source (output valid, status, reached_wire, input ready);
  modport sink   (input valid, status, reached_wire, output ready);
endinterface

interface msns_cfg_if ();
  logic valid;
  logic ready;
  logic net_type;
  modport source (output valid, net_type, input ready);
  modport sink   (input valid, net_type, output ready);
endinterface

// File: rtl/core/multistage_network_switch_setter.sv
`timescale 1ns / 1ps
// Switch setter for a self-routing butterfly/baseline network. Depends on msns_pkg, msns_if.
// One transaction at a time; each stage costs a memory read plus a check through the one
// wiring/compare unit, and a route commit one write per stage. Reset (rst_n low,
// synchronous) runs a clearing pass over the switch and blocked-mark memories before the
// first request is taken; config writes are taken always.
module multistage_network_switch_setter import msns_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  msns_in_if.sink      in_ch,
  msns_out_if.source   out_ch,
  msns_cfg_if.sink     cfg_ch
);

  // Sequencer states
  localparam logic [2:0] S_CLEAR  = 3'd0;  // memory sweep
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_BLKRD  = 3'd2;  // blocked-mark read in flight
  localparam logic [2:0] S_BLKCK  = 3'd3;
  localparam logic [2:0] S_RD     = 3'd4;  // wire permute, switch read issued
  localparam logic [2:0] S_CK     = 3'd5;  // switch checked / followed
  localparam logic [2:0] S_COMMIT = 3'd6;  // path written, one stage a cycle
  localparam logic [2:0] S_PUSH   = 3'd7;  // hand result to output register

  localparam logic [STG_W-1:0] LAST_STG = STG_W'(STAGES - 1);

  // Inter-stage wiring; stage 0 is the identity.
  function automatic logic [STAGES-1:0] wire_perm(input logic [STAGES-1:0] w,
                                                  input logic [STG_W-1:0]  s,
                                                  input logic              nt);
    logic [STAGES-1:0] r;
    int                k;
    r = w;
    if (s != '0) begin
      if (!nt) begin
        // butterfly: swap bit 0 with bit STAGES-s
        k    = STAGES - int'(s);
        r[0] = w[k];
        r[k] = w[0];
      end else begin
        // baseline: rotate the low STAGES-s+1 bits right by one
        k = STAGES - int'(s) + 1;
        for (int i = 0; i < STAGES; i++) begin
          if (i < k - 1)       r[i] = w[(i + 1) % STAGES];
          else if (i == k - 1) r[i] = w[0];
        end
      end
    end
    return r;
  endfunction

  // Control and payload registers
  logic [2:0]           state_r, state_nxt;
  logic [SW_AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic                 from_req_r, from_req_nxt;
  logic [STG_W-1:0]     stg_r, stg_nxt;
  logic [STAGES-1:0]    w_r, w_nxt;
  logic [STAGES-1:0]    src_r, src_nxt;
  logic [WIRE_W-1:0]    dest_r, dest_nxt;
  logic                 is_route_r, is_route_nxt;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic [WIRE_W-1:0]    res_wire_r, res_wire_nxt;
  logic                 net_type_r;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [WIRE_W-1:0]    out_wire_r;

  // Route path kept for the commit pass
  logic [HALF_W-1:0]    path_half_r  [STAGES];
  logic                 path_cross_r [STAGES];

  // Memories
  logic [SWC_W-1:0]     sw_mem  [SW_DEPTH];
  logic                 blk_mem [BLK_DEPTH];
  logic [SWC_W-1:0]     sw_rd_r;
  logic                 blk_rd_r;

  logic                 sw_we, blk_we, path_we;
  logic [SW_AW-1:0]     sw_waddr, sw_raddr;
  logic [SWC_W-1:0]     sw_wdata;
  logic [STAGES-1:0]    blk_waddr;
  logic                 blk_wdata;

  // Shared stage unit: permuted wire, dest bit, required setting, conflict
  logic [STAGES-1:0]    w_perm;
  logic                 dest_bit;
  logic                 need_cross;
  logic [SWC_W-1:0]     need_code;
  logic                 conflict;
  logic [STAGES-1:0]    w_after;
  logic                 in_acc, out_acc;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_valid_r && out_ch.ready;

  assign w_perm     = wire_perm(w_r, stg_r, net_type_r);
  assign sw_raddr   = {stg_r, w_perm[STAGES-1:1]};
  assign dest_bit   = dest_r[LAST_STG - stg_r];
  assign need_cross = (w_r[0] != dest_bit);
  assign need_code  = need_cross ? SW_CROSS : SW_STRAIGHT;
  assign conflict   = (sw_rd_r != SW_UNSET) && (sw_rd_r != need_code);

  always_comb begin
    if (is_route_r) w_after = {w_r[STAGES-1:1], w_r[0] ^ need_cross};
    else            w_after = {w_r[STAGES-1:1], w_r[0] ^ (sw_rd_r == SW_CROSS)};
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    from_req_nxt   = from_req_r;
    stg_nxt        = stg_r;
    w_nxt          = w_r;
    src_nxt        = src_r;
    dest_nxt       = dest_r;
    is_route_nxt   = is_route_r;
    res_status_nxt = res_status_r;
    res_wire_nxt   = res_wire_r;
    sw_we          = 1'b0;
    sw_waddr       = clr_cnt_r;
    sw_wdata       = SW_UNSET;
    blk_we         = 1'b0;
    blk_waddr      = clr_cnt_r[STAGES-1:0];
    blk_wdata      = 1'b0;
    path_we        = 1'b0;

    case (state_r)
      S_CLEAR: begin
        sw_we  = 1'b1;
        blk_we = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == SW_AW'(SW_DEPTH - 1)) begin
          if (from_req_r) begin
            res_status_nxt = ST_CLEARED;
            res_wire_nxt   = '0;
            state_nxt      = S_PUSH;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          src_nxt  = in_ch.src_wire[STAGES-1:0];
          dest_nxt = in_ch.dest_wire;
          w_nxt    = in_ch.src_wire[STAGES-1:0];
          stg_nxt  = '0;
          case (in_ch.req_type)
            REQ_CLEAR: begin
              clr_cnt_nxt  = '0;
              from_req_nxt = 1'b1;
              state_nxt    = S_CLEAR;
            end
            REQ_ROUTE: begin
              is_route_nxt = 1'b1;
              state_nxt    = S_RD;
            end
            REQ_TRACE: begin
              is_route_nxt = 1'b0;
              state_nxt    = S_BLKRD;
            end
            default: state_nxt = S_IDLE;  // code three: dropped, no result
          endcase
        end
      end
      S_BLKRD: state_nxt = S_BLKCK;
      S_BLKCK: begin
        if (blk_rd_r) begin
          res_status_nxt = ST_SKIPPED;
          res_wire_nxt   = '0;
          state_nxt      = S_PUSH;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        w_nxt     = w_perm;
        state_nxt = S_CK;
      end
      S_CK: begin
        if (is_route_r && conflict) begin
          blk_we         = 1'b1;
          blk_waddr      = src_r;
          blk_wdata      = 1'b1;
          res_status_nxt = ST_BLOCKED;
          res_wire_nxt   = '0;
          state_nxt      = S_PUSH;
        end else if (!is_route_r && sw_rd_r != SW_CROSS && sw_rd_r != SW_STRAIGHT) begin
          res_status_nxt = ST_UNSET;
          res_wire_nxt   = '0;
          state_nxt      = S_PUSH;
        end else begin
          path_we = is_route_r;
          w_nxt   = w_after;
          if (stg_r == LAST_STG) begin
            res_wire_nxt = WIRE_W'(w_after);
            stg_nxt      = '0;
            if (is_route_r) begin
              if (WIRE_W'(w_after) == dest_r) begin
                res_status_nxt = ST_ROUTED;
                state_nxt      = S_COMMIT;
              end else begin
                res_status_nxt = ST_MISDIR;
                state_nxt      = S_PUSH;
              end
            end else begin
              res_status_nxt = (WIRE_W'(w_after) == dest_r) ? ST_DELIVERED : ST_WRONG;
              state_nxt      = S_PUSH;
            end
          end else begin
            stg_nxt   = stg_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_COMMIT: begin
        sw_we    = 1'b1;
        sw_waddr = {stg_r, path_half_r[stg_r]};
        sw_wdata = path_cross_r[stg_r] ? SW_CROSS : SW_STRAIGHT;
        if (stg_r == LAST_STG) state_nxt = S_PUSH;
        else                   stg_nxt   = stg_r + 1'b1;
      end
      S_PUSH: begin
        if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      from_req_r  <= 1'b0;
      net_type_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      from_req_r <= from_req_nxt;
      if (cfg_ch.valid) net_type_r <= cfg_ch.net_type;
      if (state_r == S_PUSH && (!out_valid_r || out_ch.ready)) out_valid_r <= 1'b1;
      else if (out_acc)                                         out_valid_r <= 1'b0;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    stg_r        <= stg_nxt;
    w_r          <= w_nxt;
    src_r        <= src_nxt;
    dest_r       <= dest_nxt;
    is_route_r   <= is_route_nxt;
    res_status_r <= res_status_nxt;
    res_wire_r   <= res_wire_nxt;
    if (state_r == S_PUSH && (!out_valid_r || out_ch.ready)) begin
      out_status_r <= res_status_r;
      out_wire_r   <= res_wire_r;
    end
    if (path_we) begin
      path_half_r[stg_r]  <= w_r[STAGES-1:1];
      path_cross_r[stg_r] <= need_cross;
    end
  end

  // Switch settings and blocked marks: one write, one registered read each
  always_ff @(posedge clk) begin
    if (sw_we)  sw_mem[sw_waddr]   <= sw_wdata;
    if (blk_we) blk_mem[blk_waddr] <= blk_wdata;
    sw_rd_r  <= sw_mem[sw_raddr];
    blk_rd_r <= blk_mem[src_r];
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.reached_wire = out_wire_r;

endmodule
